// ----- rtl/core/ptwp_pkg.sv -----
// Shared types and constants for the protected-process write policy block.
// No dependencies; imported by every module in rtl/core but ptwp_ram.
package ptwp_pkg;

  localparam int PID_W   = 15;  // width of a process id field
  localparam int CNT_W   = 48;  // event counter width, counters wrap
  localparam int ROW_LG  = 5;   // log2 of bitmap bits held in one RAM row
  localparam int ROW_W   = 1 << ROW_LG;
  localparam int Q_DEPTH = 2;   // front-to-back queue entries
  localparam int Q_AW    = 1;

  // command codes
  localparam logic [1:0] CMD_PROTECT = 2'd0;
  localparam logic [1:0] CMD_FORK    = 2'd1;
  localparam logic [1:0] CMD_EXIT    = 2'd2;
  localparam logic [1:0] CMD_OPEN    = 2'd3;

  // decision codes
  localparam logic [1:0] DEC_ALLOW = 2'd0;
  localparam logic [1:0] DEC_DENY  = 2'd1;
  localparam logic [1:0] DEC_PRIOR = 2'd2;

  // path prefixes, byte 0 in the low bits
  localparam logic [39:0] PFX_TMP       = {8'h2f, 8'h70, 8'h6d, 8'h74, 8'h2f}; // "/tmp/"
  localparam logic [39:0] PFX_DEV       = {8'h2f, 8'h76, 8'h65, 8'h64, 8'h2f}; // "/dev/"
  localparam logic [63:0] PFX_PROC_HEAD = {8'h65, 8'h73, 8'h2f, 8'h63,
                                           8'h6f, 8'h72, 8'h70, 8'h2f};       // "/proc/se"
  localparam logic [23:0] PFX_PROC_TAIL = {8'h2f, 8'h66, 8'h6c};              // "lf/"
  localparam logic [7:0]  CH_N = 8'h6e;
  localparam logic [7:0]  CH_T = 8'h74;
  localparam logic [7:0]  CH_S = 8'h73;
  localparam logic [7:0]  CH_P = 8'h70;

  // classified command handed from front to back
  typedef struct packed {
    logic [1:0]       cmd;
    logic [PID_W-1:0] pid;
    logic [PID_W-1:0] child;
    logic             prior;
    logic             wmode;
    logic             allow;  // path unresolved or on the allow list
  } ptwp_item_t;

endpackage

// ----- rtl/core/pid_tree_write_policy.sv -----
// Write policy for a tree of protected processes. Commands (protect, fork, exit,
// open) enter through a push/full queue port and each gives one result on the
// pop/empty port. The protected-pid bitmap lives in a single-port RAM of
// 32-bit rows; each command passes through the back end as a read, then a
// write or decision, and a fork of a protected parent takes a further step,
// since the parent row is read before the child row is written. A two-entry
// queue after the path matcher lets new commands come in while a result waits.
// After reset the bitmap is cleared one row per cycle, all 2^(PID_BITS-5) rows
// (1024 at the default), with in_full held high.
module pid_tree_write_policy #(
  parameter int PID_BITS = 15
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  output logic                       in_full,
  input  logic [1:0]                 in_command,
  input  logic [ptwp_pkg::PID_W-1:0] in_pid,
  input  logic [ptwp_pkg::PID_W-1:0] in_child_pid,
  input  logic                       in_prior_error,
  input  logic                       in_write_mode,
  input  logic                       in_path_ok,
  input  logic [63:0]                in_path_head,
  input  logic [23:0]                in_path_tail,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic [1:0]                 out_decision,
  output logic                       out_is_protected,
  output logic [ptwp_pkg::CNT_W-1:0] out_checked_count,
  output logic [ptwp_pkg::CNT_W-1:0] out_allowed_count,
  output logic [ptwp_pkg::CNT_W-1:0] out_denied_count,
  output logic [ptwp_pkg::CNT_W-1:0] out_forked_count
);
  import ptwp_pkg::*;

  logic       clearing, q_pop, q_empty;
  ptwp_item_t q_item;

  ptwp_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_command     (in_command),
    .in_pid         (in_pid),
    .in_child_pid   (in_child_pid),
    .in_prior_error (in_prior_error),
    .in_write_mode  (in_write_mode),
    .in_path_ok     (in_path_ok),
    .in_path_head   (in_path_head),
    .in_path_tail   (in_path_tail),
    .clearing       (clearing),
    .q_pop          (q_pop),
    .q_empty        (q_empty),
    .q_item         (q_item)
  );

  ptwp_back #(.PID_BITS(PID_BITS)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .clearing          (clearing),
    .q_empty           (q_empty),
    .q_item            (q_item),
    .q_pop             (q_pop),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_decision      (out_decision),
    .out_is_protected  (out_is_protected),
    .out_checked_count (out_checked_count),
    .out_allowed_count (out_allowed_count),
    .out_denied_count  (out_denied_count),
    .out_forked_count  (out_forked_count)
  );

endmodule

// ----- rtl/core/ptwp_ram.sv -----
// Generic single-port RAM with registered read data.
// No dependencies.
module ptwp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/ptwp_front.sv -----
// Front end: accepts commands, matches the path against the allow list and
// queues classified commands for the back end. Depends on ptwp_pkg.
module ptwp_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  output logic                       in_full,
  input  logic [1:0]                 in_command,
  input  logic [ptwp_pkg::PID_W-1:0] in_pid,
  input  logic [ptwp_pkg::PID_W-1:0] in_child_pid,
  input  logic                       in_prior_error,
  input  logic                       in_write_mode,
  input  logic                       in_path_ok,
  input  logic [63:0]                in_path_head,
  input  logic [23:0]                in_path_tail,
  input  logic                       clearing,
  input  logic                       q_pop,
  output logic                       q_empty,
  output ptwp_pkg::ptwp_item_t       q_item
);
  import ptwp_pkg::*;

  ptwp_item_t         q_mem_r [Q_DEPTH];
  logic [Q_AW-1:0]    wp_r, rp_r;
  logic [Q_AW:0]      cnt_r, cnt_nxt;
  logic               push, on_list;
  ptwp_item_t         item;

  always_comb begin
    on_list = (in_path_head[39:0] == PFX_TMP) ||
              ((in_path_head[39:0] == PFX_DEV) &&
               (in_path_head[47:40] inside {CH_N, CH_T, CH_S, CH_P})) ||
              ((in_path_head == PFX_PROC_HEAD) && (in_path_tail == PFX_PROC_TAIL));
    item.cmd   = in_command;
    item.pid   = in_pid;
    item.child = in_child_pid;
    item.prior = in_prior_error;
    item.wmode = in_write_mode;
    item.allow = !in_path_ok || on_list;
  end

  assign in_full = (cnt_r == (Q_AW+1)'(Q_DEPTH)) || clearing;
  assign push    = in_push && !in_full;
  assign q_empty = (cnt_r == '0);
  assign q_item  = q_mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (q_pop) begin
        rp_r <= rp_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wp_r] <= item;
    end
  end

endmodule

// ----- rtl/core/ptwp_back.sv -----
// Back end: clears the bitmap after reset, carries out queued commands with a
// read-modify-write of the bitmap RAM, keeps the counters and holds the result.
// Depends on ptwp_pkg and ptwp_ram.
module ptwp_back #(
  parameter int PID_BITS = 15
) (
  input  logic                       clk,
  input  logic                       rst_n,
  output logic                       clearing,
  input  logic                       q_empty,
  input  ptwp_pkg::ptwp_item_t       q_item,
  output logic                       q_pop,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic [1:0]                 out_decision,
  output logic                       out_is_protected,
  output logic [ptwp_pkg::CNT_W-1:0] out_checked_count,
  output logic [ptwp_pkg::CNT_W-1:0] out_allowed_count,
  output logic [ptwp_pkg::CNT_W-1:0] out_denied_count,
  output logic [ptwp_pkg::CNT_W-1:0] out_forked_count
);
  import ptwp_pkg::*;

  localparam int RAW   = PID_BITS - ROW_LG;
  localparam int ROWS  = 1 << RAW;

  typedef enum logic [3:0] {
    S_CLR   = 4'b0001,
    S_IDLE  = 4'b0010,
    S_PDATA = 4'b0100,
    S_CDATA = 4'b1000
  } st_t;

  st_t              st_r, st_nxt;
  logic [RAW-1:0]   clr_r;
  ptwp_item_t       cur_r;
  logic [PID_BITS-1:0] p_idx, c_idx, q_idx;
  logic             start, p_bit;

  logic             ram_we;
  logic [RAW-1:0]   ram_addr;
  logic [ROW_W-1:0] ram_wdata, ram_rdata;

  logic [CNT_W-1:0] chk_r, alw_r, den_r, frk_r;
  logic [CNT_W-1:0] chk_nxt, alw_nxt, den_nxt, frk_nxt;
  logic             inc_chk, inc_alw, inc_den, inc_frk;

  logic             out_valid_r, out_valid_nxt, produce;
  logic [1:0]       dec_nxt, dec_r;
  logic             prot_nxt, prot_r;
  logic [CNT_W-1:0] o_chk_r, o_alw_r, o_den_r, o_frk_r;

  ptwp_ram #(.WIDTH(ROW_W), .DEPTH(ROWS)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign q_idx = PID_BITS'(q_item.pid);
  assign p_idx = PID_BITS'(cur_r.pid);
  assign c_idx = PID_BITS'(cur_r.child);
  assign p_bit = ram_rdata[p_idx[ROW_LG-1:0]];

  // a result slot frees up in the same cycle it is popped
  assign start    = (st_r == S_IDLE) && !q_empty && (!out_valid_r || out_pop);
  assign q_pop    = start;
  assign clearing = (st_r == S_CLR);

  always_comb begin
    st_nxt    = st_r;
    ram_we    = 1'b0;
    ram_addr  = q_idx[PID_BITS-1:ROW_LG];
    ram_wdata = ram_rdata;
    inc_chk   = 1'b0;
    inc_alw   = 1'b0;
    inc_den   = 1'b0;
    inc_frk   = 1'b0;
    produce   = 1'b0;
    dec_nxt   = DEC_ALLOW;
    prot_nxt  = p_bit;
    case (st_r)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_r;
        ram_wdata = '0;
        if (clr_r == {RAW{1'b1}}) begin
          st_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          st_nxt = S_PDATA;
        end
      end
      S_PDATA: begin
        ram_addr = p_idx[PID_BITS-1:ROW_LG];
        case (cur_r.cmd)
          CMD_PROTECT, CMD_EXIT: begin
            ram_we = 1'b1;
            ram_wdata[p_idx[ROW_LG-1:0]] = (cur_r.cmd == CMD_PROTECT);
            prot_nxt = (cur_r.cmd == CMD_PROTECT);
            produce  = 1'b1;
            st_nxt   = S_IDLE;
          end
          CMD_FORK: begin
            if (p_bit) begin
              inc_frk  = 1'b1;
              ram_addr = c_idx[PID_BITS-1:ROW_LG];
              st_nxt   = S_CDATA;
            end else begin
              produce = 1'b1;
              st_nxt  = S_IDLE;
            end
          end
          default: begin  // open check
            if (cur_r.prior) begin
              dec_nxt = DEC_PRIOR;
            end else if (p_bit && cur_r.wmode) begin
              inc_chk = 1'b1;
              if (cur_r.allow) begin
                inc_alw = 1'b1;
              end else begin
                inc_den = 1'b1;
                dec_nxt = DEC_DENY;
              end
            end
            produce = 1'b1;
            st_nxt  = S_IDLE;
          end
        endcase
      end
      S_CDATA: begin
        // row of the child is on the read port now
        ram_we    = 1'b1;
        ram_addr  = c_idx[PID_BITS-1:ROW_LG];
        ram_wdata[c_idx[ROW_LG-1:0]] = 1'b1;
        prot_nxt  = 1'b1;
        produce   = 1'b1;
        st_nxt    = S_IDLE;
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  assign chk_nxt = chk_r + CNT_W'(inc_chk);
  assign alw_nxt = alw_r + CNT_W'(inc_alw);
  assign den_nxt = den_r + CNT_W'(inc_den);
  assign frk_nxt = frk_r + CNT_W'(inc_frk);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (produce) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      chk_r       <= '0;
      alw_r       <= '0;
      den_r       <= '0;
      frk_r       <= '0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
      chk_r       <= chk_nxt;
      alw_r       <= alw_nxt;
      den_r       <= den_nxt;
      frk_r       <= frk_nxt;
      if (st_r == S_CLR) begin
        clr_r <= clr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cur_r <= q_item;
    end
    if (produce) begin
      dec_r   <= dec_nxt;
      prot_r  <= prot_nxt;
      o_chk_r <= chk_nxt;
      o_alw_r <= alw_nxt;
      o_den_r <= den_nxt;
      o_frk_r <= frk_nxt;
    end
  end

  assign out_empty         = !out_valid_r;
  assign out_decision      = dec_r;
  assign out_is_protected  = prot_r;
  assign out_checked_count = o_chk_r;
  assign out_allowed_count = o_alw_r;
  assign out_denied_count  = o_den_r;
  assign out_forked_count  = o_frk_r;

  // every examined open ends as exactly one of allowed or denied
  a_chk_sum: assert property (@(posedge clk) disable iff (!rst_n)
    chk_r == alw_r + den_r)
    else $error("checked count differs from allowed plus denied");

  a_no_pop_clr: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_CLR) |-> (!q_pop && !produce))
    else $error("command handled during bitmap clear");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_pop) |=> $stable(dec_r) && $stable(o_chk_r))
    else $error("held result changed before it was taken");

  a_fork_write: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_CDATA) |-> ($past(st_r) == S_PDATA && $past(inc_frk)))
    else $error("child write without a counted fork");

endmodule

// ----- tb/pid_tree_write_policy_test.sv -----
// Self-checking testbench for pid_tree_write_policy: protect/fork/exit/open transactions
// are pushed in, and every popped result is compared against an in-bench policy model.
// Depends on ptwp_pkg and the pid_tree_write_policy RTL only.
module pid_tree_write_policy_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ptwp_pkg::*;

  localparam int PID_BITS      = 15;
  localparam int MAP_SIZE      = 1 << PID_BITS;
  localparam int RESET_CYCLES  = 11;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 12;
  localparam int MAX_REPORTS   = 10;
  localparam int POOL_SIZE     = 12;

  typedef struct packed {
    logic [1:0]       decision;
    logic             is_protected;
    logic [CNT_W-1:0] checked;
    logic [CNT_W-1:0] allowed;
    logic [CNT_W-1:0] denied;
    logic [CNT_W-1:0] forked;
  } verdict_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_push = 1'b0;
  logic             in_full;
  logic [1:0]       in_command = CMD_PROTECT;
  logic [PID_W-1:0] in_pid = '0;
  logic [PID_W-1:0] in_child_pid = '0;
  logic             in_prior_error = 1'b0;
  logic             in_write_mode = 1'b0;
  logic             in_path_ok = 1'b0;
  logic [63:0]      in_path_head = '0;
  logic [23:0]      in_path_tail = '0;
  logic             out_empty;
  logic             out_pop = 1'b0;
  logic [1:0]       out_decision;
  logic             out_is_protected;
  logic [CNT_W-1:0] out_checked_count;
  logic [CNT_W-1:0] out_allowed_count;
  logic [CNT_W-1:0] out_denied_count;
  logic [CNT_W-1:0] out_forked_count;

  // policy model state
  logic             prot_mark [0:MAP_SIZE-1];
  logic [CNT_W-1:0] n_checked = '0;
  logic [CNT_W-1:0] n_allowed = '0;
  logic [CNT_W-1:0] n_denied  = '0;
  logic [CNT_W-1:0] n_forked  = '0;
  verdict_t         verdict_q [$];

  int               fail_count    = 0;
  int               cycle_count   = 0;
  int               send_idle_pct = 0;
  int               pop_stall_pct = 0;
  logic [PID_W-1:0] pid_pool [0:POOL_SIZE-1];

  pid_tree_write_policy #(.PID_BITS(PID_BITS)) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_command        (in_command),
    .in_pid            (in_pid),
    .in_child_pid      (in_child_pid),
    .in_prior_error    (in_prior_error),
    .in_write_mode     (in_write_mode),
    .in_path_ok        (in_path_ok),
    .in_path_head      (in_path_head),
    .in_path_tail      (in_path_tail),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_decision      (out_decision),
    .out_is_protected  (out_is_protected),
    .out_checked_count (out_checked_count),
    .out_allowed_count (out_allowed_count),
    .out_denied_count  (out_denied_count),
    .out_forked_count  (out_forked_count)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_pop <= ($urandom_range(99) >= pop_stall_pct);
  end

  // Allow list on the first 11 path bytes, byte 0 first.
  function automatic logic allow_listed(logic [63:0] head, logic [23:0] tail);
    logic [7:0] b [0:10];
    for (int i = 0; i < 8; i++) b[i] = head[8*i +: 8];
    for (int i = 0; i < 3; i++) b[8+i] = tail[8*i +: 8];
    if ({b[0], b[1], b[2], b[3], b[4]} == "/tmp/") return 1'b1;
    if ({b[0], b[1], b[2], b[3], b[4]} == "/dev/" &&
        (b[5] == "n" || b[5] == "t" || b[5] == "s" || b[5] == "p")) return 1'b1;
    if ({b[0], b[1], b[2], b[3], b[4], b[5], b[6], b[7], b[8], b[9], b[10]} == "/proc/self/")
      return 1'b1;
    return 1'b0;
  endfunction

  function automatic verdict_t apply_policy(logic [1:0] cmd, logic [PID_W-1:0] pid,
                                            logic [PID_W-1:0] child, logic prior,
                                            logic wmode, logic pok, logic [63:0] head,
                                            logic [23:0] tail);
    verdict_t            v;
    logic [PID_BITS-1:0] p;
    logic [PID_BITS-1:0] c;
    p = pid[PID_BITS-1:0];
    c = child[PID_BITS-1:0];
    v.decision = DEC_ALLOW;
    case (cmd)
      CMD_PROTECT: prot_mark[p] = 1'b1;
      CMD_FORK: begin
        if (prot_mark[p]) begin
          prot_mark[c] = 1'b1;
          n_forked = n_forked + 1'b1;
        end
      end
      CMD_EXIT: prot_mark[p] = 1'b0;
      CMD_OPEN: begin
        if (prior) begin
          v.decision = DEC_PRIOR;
        end else if (prot_mark[p] && wmode) begin
          n_checked = n_checked + 1'b1;
          if (!pok || allow_listed(head, tail)) begin
            n_allowed = n_allowed + 1'b1;
          end else begin
            n_denied = n_denied + 1'b1;
            v.decision = DEC_DENY;
          end
        end
      end
      default: ;
    endcase
    v.is_protected = prot_mark[p];
    v.checked = n_checked;
    v.allowed = n_allowed;
    v.denied  = n_denied;
    v.forked  = n_forked;
    return v;
  endfunction

  function automatic void check_field(string name, logic [CNT_W-1:0] want,
                                      logic [CNT_W-1:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h got %0h", $realtime, name, want, got);
    end
  endfunction

  // Handshakes are sampled mid-cycle, where inputs and outputs are both settled.
  always @(negedge clk) begin : transaction_monitor
    verdict_t want;
    if (rst_n && in_push && !in_full)
      verdict_q.push_back(apply_policy(in_command, in_pid, in_child_pid, in_prior_error,
                                       in_write_mode, in_path_ok, in_path_head,
                                       in_path_tail));
    if (rst_n && out_pop && !out_empty) begin
      if (verdict_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: result popped with nothing outstanding", $realtime);
      end else begin
        want = verdict_q.pop_front();
        check_field("decision", want.decision, out_decision);
        check_field("is_protected", want.is_protected, out_is_protected);
        check_field("checked_count", want.checked, out_checked_count);
        check_field("allowed_count", want.allowed, out_allowed_count);
        check_field("denied_count", want.denied, out_denied_count);
        check_field("forked_count", want.forked, out_forked_count);
      end
    end
  end

  task automatic send_command(logic [1:0] cmd, logic [PID_W-1:0] pid,
                              logic [PID_W-1:0] child, logic prior, logic wmode,
                              logic pok, logic [63:0] head, logic [23:0] tail);
    logic taken;
    if ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_push        <= 1'b1;
    in_command     <= cmd;
    in_pid         <= pid;
    in_child_pid   <= child;
    in_prior_error <= prior;
    in_write_mode  <= wmode;
    in_path_ok     <= pok;
    in_path_head   <= head;
    in_path_tail   <= tail;
    do begin
      @(negedge clk);
      taken = !in_full;
      @(posedge clk);
    end while (!taken);
  endtask

  // Zero-padded path, first character in the low byte.
  function automatic logic [87:0] path_bytes(string s);
    logic [87:0] r;
    r = '0;
    for (int i = 0; i < s.len() && i < 11; i++) r[8*i +: 8] = s[i];
    return r;
  endfunction

  task automatic open_check(logic [PID_W-1:0] pid, logic prior, logic wmode, logic pok,
                            string path);
    logic [87:0] r;
    r = path_bytes(path);
    send_command(CMD_OPEN, pid, '0, prior, wmode, pok, r[63:0], r[87:64]);
  endtask

  task automatic wait_for_results();
    in_push <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [PID_W-1:0] pick_pid();
    if ($urandom_range(4) == 0) return PID_W'($urandom);
    return pid_pool[$urandom_range(POOL_SIZE-1)];
  endfunction

  function automatic void make_path(output logic [63:0] head, output logic [23:0] tail);
    logic [87:0] bytes;
    int          kind;
    int          k;
    head = {$urandom, $urandom};
    tail = 24'($urandom);
    kind = $urandom_range(9);
    case (kind)
      0, 1: head[39:0] = PFX_TMP;
      2, 3: begin
        head[39:0] = PFX_DEV;
        case ($urandom_range(3))
          0: head[47:40] = CH_N;
          1: head[47:40] = CH_T;
          2: head[47:40] = CH_S;
          default: head[47:40] = CH_P;
        endcase
      end
      4: begin
        head = PFX_PROC_HEAD;
        tail = PFX_PROC_TAIL;
      end
      5: head[39:0] = PFX_DEV;
      6, 7: begin
        // near miss: one flipped bit in an otherwise allowed path
        if (kind == 6) begin
          head = PFX_PROC_HEAD;
          tail = PFX_PROC_TAIL;
        end else begin
          head[39:0] = PFX_TMP;
        end
        bytes = {tail, head};
        k = $urandom_range(kind == 6 ? 87 : 39);
        bytes[k] = ~bytes[k];
        head = bytes[63:0];
        tail = bytes[87:64];
      end
      default: ;
    endcase
  endfunction

  task automatic send_random_command();
    logic [1:0]       cmd;
    logic [PID_W-1:0] pid;
    logic [PID_W-1:0] child;
    logic [63:0]      head;
    logic [23:0]      tail;
    int               roll;
    roll = $urandom_range(99);
    if (roll < 15)      cmd = CMD_PROTECT;
    else if (roll < 35) cmd = CMD_FORK;
    else if (roll < 45) cmd = CMD_EXIT;
    else                cmd = CMD_OPEN;
    pid   = pick_pid();
    child = pick_pid();
    make_path(head, tail);
    send_command(cmd, pid, child, $urandom_range(99) < 10, $urandom_range(99) < 75,
                 $urandom_range(99) < 85, head, tail);
  endtask

  task automatic test_quiet_map();
    open_check(15'h0000, 1'b0, 1'b1, 1'b1, "/etc/passwd");
    open_check(15'h7fff, 1'b0, 1'b1, 1'b1, "/bin/sh");
  endtask

  task automatic test_mark_lifecycle();
    send_command(CMD_PROTECT, 15'h0000, '0, 1'b0, 1'b0, 1'b0, '0, '0);
    send_command(CMD_PROTECT, 15'h7fff, '0, 1'b0, 1'b0, 1'b0, '0, '0);
    // fork onto itself: mark stays, still counted
    send_command(CMD_FORK, 15'h7fff, 15'h7fff, 1'b0, 1'b0, 1'b0, '0, '0);
    send_command(CMD_EXIT, 15'h0000, '0, 1'b0, 1'b0, 1'b0, '0, '0);
    open_check(15'h0000, 1'b0, 1'b1, 1'b1, "/etc/shadow");
  endtask

  task automatic test_fork_inheritance();
    send_command(CMD_FORK, 15'h2000, 15'h1555, 1'b0, 1'b0, 1'b0, '0, '0);
    send_command(CMD_PROTECT, 15'h1555, '0, 1'b0, 1'b0, 1'b0, '0, '0);
    // unmarked parent leaves the child's mark alone
    send_command(CMD_FORK, 15'h2000, 15'h1555, 1'b0, 1'b0, 1'b0, '0, '0);
    send_command(CMD_FORK, 15'h1555, 15'h2aaa, 1'b0, 1'b0, 1'b0, '0, '0);
    send_command(CMD_EXIT, 15'h7fff, '0, 1'b0, 1'b0, 1'b0, '0, '0);
  endtask

  task automatic test_open_policy();
    open_check(15'h2aaa, 1'b0, 1'b1, 1'b1, "/tmp/x");
    open_check(15'h2aaa, 1'b0, 1'b1, 1'b1, "/dev/null");
    open_check(15'h2aaa, 1'b0, 1'b1, 1'b1, "/dev/tty1");
    open_check(15'h2aaa, 1'b0, 1'b1, 1'b1, "/dev/sda");
    open_check(15'h2aaa, 1'b0, 1'b1, 1'b1, "/dev/pts/0");
    open_check(15'h2aaa, 1'b0, 1'b1, 1'b1, "/dev/xvda");
    open_check(15'h2aaa, 1'b0, 1'b1, 1'b1, "/proc/self/");
    open_check(15'h2aaa, 1'b0, 1'b1, 1'b1, "/proc/selfx");
    open_check(15'h2aaa, 1'b0, 1'b1, 1'b1, "/tmpx");
    open_check(15'h2aaa, 1'b0, 1'b1, 1'b0, "/etc/hosts");
    open_check(15'h2aaa, 1'b0, 1'b0, 1'b1, "/etc/hosts");
    open_check(15'h2aaa, 1'b1, 1'b1, 1'b1, "/etc/hosts");
    open_check(15'h0000, 1'b1, 1'b0, 1'b0, "/tmp/");
    send_command(CMD_OPEN, 15'h2aaa, '1, 1'b0, 1'b1, 1'b1, '1, '1);
  endtask

  task automatic test_random_traffic(int count, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    pop_stall_pct = stall_pct;
    pid_pool[0] = '0;
    pid_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) pid_pool[i] = PID_W'($urandom);
    repeat (count) send_random_command();
    wait_for_results();
  endtask

  initial begin
    foreach (prot_mark[i]) prot_mark[i] = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_quiet_map();
    test_mark_lifecycle();
    test_fork_inheritance();
    test_open_policy();
    wait_for_results();

    test_random_traffic(150, 0, 0);
    test_random_traffic(150, 60, 0);
    test_random_traffic(150, 0, 60);
    test_random_traffic(150, 14, 14);

    repeat (SETTLE_CYCLES) @(posedge clk);
    fail_count += verdict_q.size();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- pid_tree_write_policy.f -----
rtl/core/ptwp_pkg.sv
rtl/core/ptwp_ram.sv
rtl/core/ptwp_front.sv
rtl/core/ptwp_back.sv
rtl/core/pid_tree_write_policy.sv
tb/pid_tree_write_policy_test.sv
